FILE: sv/wall_table_ray_and_circle_query_macros.svh
// Assertion macros shared by the checker of the wall table block.
`ifndef WALL_TABLE_RAY_AND_CIRCLE_QUERY_MACROS_SVH
`define WALL_TABLE_RAY_AND_CIRCLE_QUERY_MACROS_SVH

// Same-cycle implication under reset.
`define WTQ_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("wall table check failed");

// Next-cycle implication under reset.
`define WTQ_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("wall table check failed");

`endif

FILE: sv/wtq_pkg.sv
// ----------------------------------------------------------------------------
// wtq_pkg
// Constants, request codes and divider handshake types of the wall table.
// ----------------------------------------------------------------------------
package wtq_pkg;

    localparam int MAX_WALLS = 64;
    localparam int IDX_W     = $clog2(MAX_WALLS);
    localparam int CNT_W     = 7;
    localparam int NUM_W     = 37;   // (edge - origin) << 14
    localparam int DEN_W     = 16;
    localparam int T_W       = 39;   // slab distance, signed
    localparam int ITER_W    = $clog2(NUM_W + 1);

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_RAY    = 2'd2;
    localparam logic [1:0] REQ_CIRCLE = 2'd3;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [T_W-1:0] quo;
    } div_rsp_t;

endpackage

FILE: sv/wtq_divider.sv
// ----------------------------------------------------------------------------
// wtq_divider
// Shared radix-2 restoring divider with floor rounding, one bit per cycle.
// ----------------------------------------------------------------------------
module wtq_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  wtq_pkg::div_req_t div_req,
    output wtq_pkg::div_rsp_t div_rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [wtq_pkg::ITER_W-1:0]    cnt_reg, cnt_next;
    logic                          neg_reg, neg_next;
    logic [wtq_pkg::NUM_W-1:0]     quo_reg, quo_next;
    logic [wtq_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [wtq_pkg::DEN_W-1:0]     den_reg, den_next;

    logic [wtq_pkg::NUM_W-1:0]     num_mag;
    logic [wtq_pkg::DEN_W-1:0]     den_mag;
    logic [wtq_pkg::DEN_W:0]       rem_sh;
    logic [wtq_pkg::DEN_W+1:0]     sub;
    logic [wtq_pkg::T_W-1:0]       mag_ext;

    assign num_mag = div_req.num[wtq_pkg::NUM_W-1] ? wtq_pkg::NUM_W'(-div_req.num)
                                                  : div_req.num;
    assign den_mag = div_req.den[wtq_pkg::DEN_W-1] ? wtq_pkg::DEN_W'(-div_req.den)
                                                  : div_req.den;
    assign rem_sh  = {rem_reg, quo_reg[wtq_pkg::NUM_W-1]};
    assign sub     = {1'b0, rem_sh} - {2'b00, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (div_req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = wtq_pkg::ITER_W'(wtq_pkg::NUM_W);
            neg_next  = div_req.num[wtq_pkg::NUM_W-1] ^ div_req.den[wtq_pkg::DEN_W-1];
            quo_next  = num_mag;
            rem_next  = '0;
            den_next  = den_mag;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[wtq_pkg::NUM_W-2:0], ~sub[wtq_pkg::DEN_W+1]};
            rem_next = sub[wtq_pkg::DEN_W+1] ? rem_sh[wtq_pkg::DEN_W-1:0]
                                             : sub[wtq_pkg::DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == wtq_pkg::ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // A negative quotient with a remainder rounds one step further down.
    assign mag_ext      = {{(wtq_pkg::T_W-wtq_pkg::NUM_W){1'b0}}, quo_reg};
    assign div_rsp.done = done_reg;
    assign div_rsp.quo  = neg_reg ? (-mag_ext - wtq_pkg::T_W'(rem_reg != '0)) : mag_ext;

endmodule

FILE: sv/wall_table_ray_and_circle_query.sv
// ----------------------------------------------------------------------------
// wall_table_ray_and_circle_query
// Wall rectangle table with nearest ray entry search and circle overlap test.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  req      req_valid/req_ready   req_type pos_x pos_y dir_x dir_y limit rect_*
//  rsp      rsp_valid/rsp_ready   flag distance walls_held
//
// Add and clear go straight to the response state. A raycast walks every
// stored wall with up to four divisions per wall in the shared divider. A
// circle test walks the stored walls, stopping at the first overlap. Reset
// clears the count; the table is never swept. One request is in work at a
// time; a result waiting on rsp_ready does not block the next request, only
// the one after it.
// ----------------------------------------------------------------------------
module wall_table_ray_and_circle_query (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         req_type,
    input  logic signed [20:0] pos_x,
    input  logic signed [20:0] pos_y,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic [19:0]        limit,
    input  logic [11:0]        rect_x,
    input  logic [11:0]        rect_y,
    input  logic [11:0]        rect_w,
    input  logic [11:0]        rect_h,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic               flag,
    output logic [19:0]        distance,
    output logic [6:0]         walls_held
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CR    = 4'd1;
    localparam logic [3:0] ST_CR2   = 4'd2;
    localparam logic [3:0] ST_FETCH = 4'd3;
    localparam logic [3:0] ST_AXIS  = 4'd4;
    localparam logic [3:0] ST_DIVA  = 4'd5;
    localparam logic [3:0] ST_DIVB  = 4'd6;
    localparam logic [3:0] ST_SLAB  = 4'd7;
    localparam logic [3:0] ST_CX    = 4'd8;
    localparam logic [3:0] ST_CY    = 4'd9;
    localparam logic [3:0] ST_CCMP  = 4'd10;
    localparam logic [3:0] ST_NEXT  = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;

    localparam int T_W = wtq_pkg::T_W;

    logic [3:0]                  state_reg, state_next;
    logic [wtq_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [wtq_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        axis_reg, axis_next;
    logic                        flag_reg, flag_next;
    logic [19:0]                 best_reg, best_next;
    logic signed [T_W-1:0]       tmin_reg, tmin_next;
    logic signed [T_W-1:0]       tmax_reg, tmax_next;
    logic signed [T_W-1:0]       t0_reg, t0_next;
    logic signed [T_W-1:0]       t1_reg, t1_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic                        rsp_flag_reg, rsp_flag_next;
    logic [19:0]                 rsp_dist_reg, rsp_dist_next;
    logic [6:0]                  rsp_held_reg, rsp_held_next;

    logic [1:0]                  type_reg;
    logic signed [20:0]          px_reg, py_reg;
    logic signed [15:0]          dx_reg, dy_reg;
    logic [19:0]                 lim_reg;
    logic [47:0]                 rd_reg;
    logic signed [47:0]          prod_reg;
    logic [46:0]                 sqx_reg;
    logic [39:0]                 r2_reg;

    logic [47:0]                 wall_mem [wtq_pkg::MAX_WALLS];

    logic                        accept;
    logic                        add_ok;
    logic [11:0]                 w_x, w_y, w_w, w_h;
    logic [11:0]                 ax_lo, ax_len;
    logic [12:0]                 ax_hi;
    logic signed [22:0]          lo_s, hi_s, org_s;
    logic signed [15:0]          dir_ax;
    logic signed [22:0]          diff_lo, diff_hi;
    logic                        org_in;
    logic signed [T_W-1:0]       tlo, thi, tmin_n, tmax_n;
    logic signed [T_W-1:0]       best_s;
    logic signed [23:0]          cx_lo, cx_hi, cy_lo, cy_hi, px24, py24;
    logic signed [23:0]          cx, cy, ex, ey, mul_a;
    logic [47:0]                 circ_sum;
    logic                        last_wall;
    wtq_pkg::div_req_t           div_req;
    wtq_pkg::div_rsp_t           div_rsp;

    wtq_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    assign accept = req_valid && req_ready;
    assign add_ok = (rect_w != '0) && (rect_h != '0)
                    && (count_reg < wtq_pkg::CNT_W'(wtq_pkg::MAX_WALLS));

    // Stored wall fields and the bounds of the axis in work.
    assign w_x    = rd_reg[47:36];
    assign w_y    = rd_reg[35:24];
    assign w_w    = rd_reg[23:12];
    assign w_h    = rd_reg[11:0];
    assign ax_lo  = axis_reg ? w_y : w_x;
    assign ax_len = axis_reg ? w_h : w_w;
    assign ax_hi  = {1'b0, ax_lo} + {1'b0, ax_len};
    assign lo_s   = signed'({3'b000, ax_lo, 8'h00});
    assign hi_s   = signed'({2'b00, ax_hi, 8'h00});
    assign org_s  = axis_reg ? 23'(py_reg) : 23'(px_reg);
    assign dir_ax = axis_reg ? dy_reg : dx_reg;
    assign diff_lo = lo_s - org_s;
    assign diff_hi = hi_s - org_s;
    assign org_in  = (org_s >= lo_s) && (org_s <= hi_s);

    assign div_req.start = ((state_reg == ST_AXIS) && (dir_ax != '0))
                           || ((state_reg == ST_DIVA) && div_rsp.done);
    assign div_req.num   = (state_reg == ST_DIVA) ? {diff_hi, 14'h0000}
                                                  : {diff_lo, 14'h0000};
    assign div_req.den   = dir_ax;

    assign tlo    = (t0_reg > t1_reg) ? t1_reg : t0_reg;
    assign thi    = (t0_reg > t1_reg) ? t0_reg : t1_reg;
    assign tmin_n = (tlo > tmin_reg) ? tlo : tmin_reg;
    assign tmax_n = (thi < tmax_reg) ? thi : tmax_reg;
    assign best_s = signed'(T_W'(best_reg));

    // Closest point of the wall to the circle centre.
    assign px24  = 24'(px_reg);
    assign py24  = 24'(py_reg);
    assign cx_lo = signed'({4'h0, w_x, 8'h00});
    assign cx_hi = signed'({3'b000, {1'b0, w_x} + {1'b0, w_w}, 8'h00});
    assign cy_lo = signed'({4'h0, w_y, 8'h00});
    assign cy_hi = signed'({3'b000, {1'b0, w_y} + {1'b0, w_h}, 8'h00});
    assign cx    = (px24 < cx_lo) ? cx_lo : ((px24 > cx_hi) ? cx_hi : px24);
    assign cy    = (py24 < cy_lo) ? cy_lo : ((py24 > cy_hi) ? cy_hi : py24);
    assign ex    = px24 - cx;
    assign ey    = py24 - cy;

    always_comb
    begin
        case (state_reg)
            ST_CR:   mul_a = signed'({4'h0, lim_reg});
            ST_CX:   mul_a = ex;
            default: mul_a = ey;
        endcase
    end

    assign circ_sum  = {1'b0, sqx_reg} + {1'b0, prod_reg[46:0]};
    assign last_wall = ({1'b0, idx_reg} + 1'b1) == count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        axis_next      = axis_reg;
        flag_next      = flag_reg;
        best_next      = best_reg;
        tmin_next      = tmin_reg;
        tmax_next      = tmax_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_flag_next  = rsp_flag_reg;
        rsp_dist_next  = rsp_dist_reg;
        rsp_held_next  = rsp_held_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = '0;
                    flag_next = 1'b0;
                    best_next = '0;
                    state_next = ST_FIN;
                    case (req_type)
                        wtq_pkg::REQ_ADD:
                        begin
                            flag_next = add_ok;
                            if (add_ok)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        wtq_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        wtq_pkg::REQ_RAY:
                        begin
                            best_next = limit;
                            if (count_reg != '0)
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_CR;
                            end
                        end
                    endcase
                end
            end
            ST_CR:
            begin
                state_next = ST_CR2;
            end
            ST_CR2:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                axis_next = 1'b0;
                tmin_next = '0;
                tmax_next = best_s;
                state_next = (type_reg == wtq_pkg::REQ_RAY) ? ST_AXIS : ST_CX;
            end
            ST_AXIS:
            begin
                if (dir_ax != '0)
                begin
                    state_next = ST_DIVA;
                end
                else if (!org_in)
                begin
                    state_next = ST_NEXT;
                end
                else if (!axis_reg)
                begin
                    axis_next = 1'b1;
                end
                else
                begin
                    if (tmin_reg < best_s)
                    begin
                        best_next = tmin_reg[19:0];
                    end
                    state_next = ST_NEXT;
                end
            end
            ST_DIVA:
            begin
                if (div_rsp.done)
                begin
                    t0_next    = div_rsp.quo;
                    state_next = ST_DIVB;
                end
            end
            ST_DIVB:
            begin
                if (div_rsp.done)
                begin
                    t1_next    = div_rsp.quo;
                    state_next = ST_SLAB;
                end
            end
            ST_SLAB:
            begin
                tmin_next = tmin_n;
                tmax_next = tmax_n;
                if (tmin_n > tmax_n)
                begin
                    state_next = ST_NEXT;
                end
                else if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_AXIS;
                end
                else
                begin
                    if (tmin_n < best_s)
                    begin
                        best_next = tmin_n[19:0];
                    end
                    state_next = ST_NEXT;
                end
            end
            ST_CX:
            begin
                state_next = ST_CY;
            end
            ST_CY:
            begin
                state_next = ST_CCMP;
            end
            ST_CCMP:
            begin
                if (circ_sum < {8'h00, r2_reg})
                begin
                    flag_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (last_wall)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_dist_next  = best_reg;
                    rsp_held_next  = count_reg;
                    rsp_flag_next  = (type_reg == wtq_pkg::REQ_RAY) ? (best_reg < lim_reg)
                                                                    : flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        axis_reg     <= axis_next;
        flag_reg     <= flag_next;
        best_reg     <= best_next;
        tmin_reg     <= tmin_next;
        tmax_reg     <= tmax_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        rsp_flag_reg <= rsp_flag_next;
        rsp_dist_reg <= rsp_dist_next;
        rsp_held_reg <= rsp_held_next;
        prod_reg     <= mul_a * mul_a;
        if (state_reg == ST_CR2)
        begin
            r2_reg <= prod_reg[39:0];
        end
        if (state_reg == ST_CY)
        begin
            sqx_reg <= prod_reg[46:0];
        end
        if (accept)
        begin
            type_reg <= req_type;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            dx_reg   <= dir_x;
            dy_reg   <= dir_y;
            lim_reg  <= limit;
        end
    end

    // Wall table: written on an accepted add that is not refused, read at the walk index.
    always_ff @(posedge clk)
    begin
        if (accept && (req_type == wtq_pkg::REQ_ADD) && add_ok)
        begin
            wall_mem[count_reg[wtq_pkg::IDX_W-1:0]] <= {rect_x, rect_y, rect_w, rect_h};
        end
        rd_reg <= wall_mem[idx_reg];
    end

    assign req_ready  = (state_reg == ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign flag       = rsp_flag_reg;
    assign distance   = rsp_dist_reg;
    assign walls_held = rsp_held_reg;

endmodule

FILE: sv/wtq_checker.sv
// ----------------------------------------------------------------------------
// wtq_checker
// Port-level checks of the wall table block, bound to the top level.
// ----------------------------------------------------------------------------
`include "wall_table_ray_and_circle_query_macros.svh"

module wtq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               flag,
    input logic [19:0]        distance,
    input logic [6:0]         walls_held
);

    // A request is worked on alone, so the port closes after each beat.
    `WTQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // The table never reports more walls than it can hold.
    `WTQ_ASSERT_IMPL(a_held_range, clk, rst_n, rsp_valid, walls_held <= 7'd64)

    // A stalled result beat holds its distance and flag.
    `WTQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(distance) && $stable(flag))

endmodule

bind wall_table_ray_and_circle_query wtq_checker u_wtq_checker (.*);

FILE: tb/sv/tb_wall_table_ray_and_circle_query.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wall_table_ray_and_circle_query
// Drives add, clear, raycast and circle requests into the wall table and checks
// every response beat against a local wall table predictor, with and without
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_wall_table_ray_and_circle_query;

    typedef struct {
        logic       flag;
        logic [19:0] distance;
        logic [6:0]  walls_held;
    } wall_rsp_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [1:0]         req_type;
    logic signed [20:0] pos_x;
    logic signed [20:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [19:0]        limit;
    logic [11:0]        rect_x;
    logic [11:0]        rect_y;
    logic [11:0]        rect_w;
    logic [11:0]        rect_h;
    logic               rsp_valid;
    logic               rsp_ready;
    logic               flag;
    logic [19:0]        distance;
    logic [6:0]         walls_held;

    // Predictor copy of the wall table.
    logic [11:0] tbl_x [wtq_pkg::MAX_WALLS];
    logic [11:0] tbl_y [wtq_pkg::MAX_WALLS];
    logic [11:0] tbl_w [wtq_pkg::MAX_WALLS];
    logic [11:0] tbl_h [wtq_pkg::MAX_WALLS];
    int          tbl_count;

    wall_rsp_t   pending_rsp[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    wall_table_ray_and_circle_query u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .limit      (limit),
        .rect_x     (rect_x),
        .rect_y     (rect_y),
        .rect_w     (rect_w),
        .rect_h     (rect_h),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .flag       (flag),
        .distance   (distance),
        .walls_held (walls_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    // Slab entry distance into one wall, or -1 when the ray misses it.
    function automatic longint slab_entry_dist(longint ox, longint oy, longint dx,
                                               longint dy, int idx, longint tmax);
        longint tmin;
        longint lo[2];
        longint hi[2];
        longint org[2];
        longint dv[2];
        longint t0;
        longint t1;
        longint tt;
        tmin = 0;
        lo[0] = longint'(tbl_x[idx]) * 256;
        lo[1] = longint'(tbl_y[idx]) * 256;
        hi[0] = (longint'(tbl_x[idx]) + longint'(tbl_w[idx])) * 256;
        hi[1] = (longint'(tbl_y[idx]) + longint'(tbl_h[idx])) * 256;
        org[0] = ox;
        org[1] = oy;
        dv[0] = dx;
        dv[1] = dy;
        for (int a = 0; a < 2; a++)
        begin
            if (dv[a] == 0)
            begin
                if (org[a] < lo[a] || org[a] > hi[a])
                    return -1;
            end
            else
            begin
                t0 = floor_quot((lo[a] - org[a]) * 16384, dv[a]);
                t1 = floor_quot((hi[a] - org[a]) * 16384, dv[a]);
                if (t0 > t1)
                begin
                    tt = t0;
                    t0 = t1;
                    t1 = tt;
                end
                if (t0 > tmin)
                    tmin = t0;
                if (t1 < tmax)
                    tmax = t1;
                if (tmin > tmax)
                    return -1;
            end
        end
        return tmin;
    endfunction

    function automatic longint clamp_edge(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Applies one accepted request to the predictor and returns its response.
    function automatic wall_rsp_t predict_wall_rsp();
        wall_rsp_t r;
        longint    px;
        longint    py;
        longint    lim;
        longint    best;
        longint    t;
        longint    ex;
        longint    ey;
        r.flag = 1'b0;
        r.distance = '0;
        px = longint'(pos_x);
        py = longint'(pos_y);
        lim = longint'(limit);
        case (req_type)
            wtq_pkg::REQ_ADD:
            begin
                if (rect_w != 0 && rect_h != 0 && tbl_count < wtq_pkg::MAX_WALLS)
                begin
                    tbl_x[tbl_count] = rect_x;
                    tbl_y[tbl_count] = rect_y;
                    tbl_w[tbl_count] = rect_w;
                    tbl_h[tbl_count] = rect_h;
                    tbl_count++;
                    r.flag = 1'b1;
                end
            end
            wtq_pkg::REQ_CLEAR:
                tbl_count = 0;
            wtq_pkg::REQ_RAY:
            begin
                best = lim;
                for (int i = 0; i < tbl_count; i++)
                begin
                    t = slab_entry_dist(px, py, longint'(dir_x), longint'(dir_y), i, best);
                    if (t >= 0 && t < best)
                        best = t;
                end
                r.flag = (best < lim);
                r.distance = best[19:0];
            end
            default:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    ex = px - clamp_edge(px, longint'(tbl_x[i]) * 256,
                                         (longint'(tbl_x[i]) + longint'(tbl_w[i])) * 256);
                    ey = py - clamp_edge(py, longint'(tbl_y[i]) * 256,
                                         (longint'(tbl_y[i]) + longint'(tbl_h[i])) * 256);
                    if (ex * ex + ey * ey < lim * lim)
                    begin
                        r.flag = 1'b1;
                        break;
                    end
                end
            end
        endcase
        r.walls_held = tbl_count[6:0];
        return r;
    endfunction

    // Sends one request beat; valid stays high across back-to-back beats.
    task automatic send_wall_req(logic [1:0] kind, int px, int py, int dx, int dy,
                                 int lim, int rx, int ry, int rw, int rh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_type = kind;
        pos_x = px[20:0];
        pos_y = py[20:0];
        dir_x = dx[15:0];
        dir_y = dy[15:0];
        limit = lim[19:0];
        rect_x = rx[11:0];
        rect_y = ry[11:0];
        rect_w = rw[11:0];
        rect_h = rh[11:0];
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        pending_rsp.push_back(predict_wall_rsp());
        @(negedge clk);
    endtask

    task automatic send_add(int rx, int ry, int rw, int rh);
        send_wall_req(wtq_pkg::REQ_ADD, 0, 0, 0, 0, 0, rx, ry, rw, rh);
    endtask

    task automatic send_clear();
        send_wall_req(wtq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic send_ray(int px, int py, int dx, int dy, int lim);
        send_wall_req(wtq_pkg::REQ_RAY, px, py, dx, dy, lim, 0, 0, 0, 0);
    endtask

    task automatic send_circle(int px, int py, int lim);
        send_wall_req(wtq_pkg::REQ_CIRCLE, px, py, 0, 0, lim, 0, 0, 0, 0);
    endtask

    task automatic wait_all_rsp();
        req_valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        wall_rsp_t exp_rsp;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response beat at %0t", $realtime);
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    if (flag !== exp_rsp.flag || distance !== exp_rsp.distance
                        || walls_held !== exp_rsp.walls_held)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch at %0t: exp flag %0d dist %0d held %0d, got %0d %0d %0d",
                                     $realtime, exp_rsp.flag, exp_rsp.distance,
                                     exp_rsp.walls_held, flag, distance, walls_held);
                    end
                end
            end
        end
    end

    // Adds, clears and the zero size refusals.
    task automatic test_table_edits();
        send_add(0, 0, 0, 5);
        send_add(4095, 4095, 4095, 0);
        send_add(4095, 4095, 4095, 4095);
        send_add(0, 0, 1, 1);
        send_add(10, 10, 4, 2);
        send_clear();
        send_add(10, 10, 4, 2);
        send_add(20, 0, 2, 30);
    endtask

    // Rays with zero components, limits at the edges, and circles.
    task automatic test_queries();
        send_ray(0, 11 * 256, 16384, 0, 100 * 256);
        send_ray(12 * 256, 0, 0, 16384, 100 * 256);
        send_ray(12 * 256, 11 * 256, 0, 0, 5);
        send_ray(12 * 256, 11 * 256, 0, 0, 0);
        send_ray(0, 11 * 256, 16384, 0, 10 * 256);
        send_ray(-1048576, -1048576, 32767, 32767, 1048575);
        send_ray(1048575, 1048575, -32768, -32768, 1048575);
        send_circle(8 * 256, 11 * 256, 2 * 256);
        send_circle(8 * 256, 11 * 256, 2 * 256 + 1);
        send_circle(1048575, -1048576, 1048575);
        send_circle(12 * 256, 11 * 256, 0);
    endtask

    // Fills the table, is refused when full, queries it, then empties it.
    task automatic test_table_full();
        send_clear();
        for (int i = 0; i < wtq_pkg::MAX_WALLS; i++)
            send_add($urandom_range(200), $urandom_range(200), $urandom_range(1, 8),
                     $urandom_range(1, 8));
        send_add(1, 1, 1, 1);
        send_ray(0, 0, $urandom_range(1, 16384), $urandom_range(1, 16384), 1048575);
        send_circle(100 * 256, 100 * 256, 20 * 256);
        wait_all_rsp();
        send_clear();
    endtask

    task automatic send_random_item();
        int pick;
        int px;
        int py;
        int dx;
        int dy;
        int lim;
        pick = $urandom_range(99);
        if (pick < 5 || (tbl_count > 20 && pick < 30))
            send_clear();
        else if (pick < 35)
        begin
            if ($urandom_range(9) == 0)
                send_add($urandom, $urandom, $urandom, $urandom);
            else
                send_add($urandom_range(60), $urandom_range(60), $urandom_range(12),
                         $urandom_range(12));
        end
        else
        begin
            if ($urandom_range(9) == 0)
            begin
                px = $urandom;
                py = $urandom;
                lim = $urandom;
            end
            else
            begin
                px = $urandom_range(80 * 256) - 10 * 256;
                py = $urandom_range(80 * 256) - 10 * 256;
                lim = ($urandom_range(3) == 0) ? $urandom : $urandom_range(60 * 256);
            end
            if (pick < 68)
            begin
                dx = ($urandom_range(7) == 0) ? 0 : $urandom;
                dy = ($urandom_range(7) == 0) ? 0 : $urandom;
                send_ray(px, py, dx, dy, lim);
            end
            else
                send_circle(px, py, lim);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_random_item();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = wtq_pkg::REQ_ADD;
        pos_x = '0;
        pos_y = '0;
        dir_x = '0;
        dir_y = '0;
        limit = '0;
        rect_x = '0;
        rect_y = '0;
        rect_w = '0;
        rect_h = '0;
        tbl_count = 0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 66;
        test_table_edits();
        test_queries();
        test_random(60);

        send_idle_pct = 66;
        recv_idle_pct = 25;
        test_table_full();
        test_random(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(80);

        wait_all_rsp();
        repeat (50) @(negedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
